### design/afd_pkg.sv
package afd_pkg;

  // field and register widths
  localparam int unsigned ByteW    = 8;
  localparam int unsigned NibW     = 4;
  localparam int unsigned SampleW  = 16;
  localparam int unsigned CoefW    = 16;
  localparam int unsigned CfgDataW = 64;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned LimitW   = 24;
  localparam int unsigned NumCoefWords = 4;
  localparam int unsigned ScaleW   = 4;
  localparam int unsigned PredW    = 3;
  localparam int unsigned PosW     = 3;

  // fixed point of the predictor sum
  localparam int unsigned FracShift = 11;
  localparam int          RoundBias = 1024;
  // wide enough for nibble << 26 plus two 32-bit products, no overflow
  localparam int unsigned AccW      = 34;
  localparam int unsigned ShW       = 5;

  localparam logic [PosW-1:0]   FrameDataBytes = 3'd7;
  localparam logic [PosW-1:0]   PosHeader      = 3'd0;
  localparam logic [PosW-1:0]   PosFirstData   = 3'd1;
  localparam logic [LimitW-1:0] LimitReset     = 24'hFF_FFFF;

  localparam logic signed [SampleW-1:0] SampleMax = 16'sh7FFF;
  localparam logic signed [SampleW-1:0] SampleMin = 16'sh8000;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_COEF_A       = 3'd0,
    CFG_COEF_B       = 3'd1,
    CFG_COEF_C       = 3'd2,
    CFG_COEF_D       = 3'd3,
    CFG_SAMPLE_LIMIT = 3'd4
  } cfg_idx_e;

  // operands of one sample computation
  typedef struct packed {
    logic [NibW-1:0]           nibble;
    logic [ScaleW-1:0]         scale_exp;
    logic signed [CoefW-1:0]   coef_newer;
    logic signed [CoefW-1:0]   coef_older;
    logic signed [SampleW-1:0] hist_newer;
    logic signed [SampleW-1:0] hist_older;
  } calc_in_t;

  typedef struct packed {
    logic signed [SampleW-1:0] sample;
    logic                      clipped;
  } calc_out_t;

endpackage

### design/afd_if.sv
interface afd_in_if;
  logic                       valid;
  logic                       ready;
  logic [afd_pkg::ByteW-1:0]  data_byte;
  logic                       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface afd_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [afd_pkg::SampleW-1:0] pcm_sample;
  logic                               was_clipped;
  logic                               run_end;

  modport source (output valid, output pcm_sample, output was_clipped, output run_end,
                  input ready);
  modport sink   (input valid, input pcm_sample, input was_clipped, input run_end,
                  output ready);
endinterface

### design/afd_sample_calc.sv
module afd_sample_calc (
  input  afd_pkg::calc_in_t  calc_i,
  output afd_pkg::calc_out_t calc_o
);

  localparam int unsigned SW = afd_pkg::AccW - afd_pkg::FracShift;

  logic signed [afd_pkg::AccW-1:0]      nib_ext;
  logic [afd_pkg::ShW-1:0]              shamt;
  logic signed [afd_pkg::AccW-1:0]      scaled;
  logic signed [2*afd_pkg::CoefW-1:0]   prod_newer;
  logic signed [2*afd_pkg::CoefW-1:0]   prod_older;
  logic signed [afd_pkg::AccW-1:0]      acc;
  logic signed [SW-1:0]                 shifted;
  logic                                 over;
  logic                                 under;

  assign nib_ext = afd_pkg::AccW'($signed(calc_i.nibble));
  assign shamt   = afd_pkg::ShW'(calc_i.scale_exp) + afd_pkg::ShW'(afd_pkg::FracShift);
  assign scaled  = nib_ext <<< shamt;

  assign prod_newer = $signed(calc_i.coef_newer) * $signed(calc_i.hist_newer);
  assign prod_older = $signed(calc_i.coef_older) * $signed(calc_i.hist_older);

  assign acc = scaled + afd_pkg::AccW'(prod_newer) + afd_pkg::AccW'(prod_older)
             + afd_pkg::AccW'(afd_pkg::RoundBias);

  // arithmetic shift = floor division
  assign shifted = $signed(acc[afd_pkg::AccW-1:afd_pkg::FracShift]);

  // out of range when the sample sign bit or any bit above it disagrees with the top bit
  assign over  = !shifted[SW-1] && (|shifted[SW-2:afd_pkg::SampleW-1]);
  assign under =  shifted[SW-1] && !(&shifted[SW-2:afd_pkg::SampleW-1]);

  always_comb begin
    calc_o.clipped = over || under;
    if (over) begin
      calc_o.sample = afd_pkg::SampleMax;
    end else if (under) begin
      calc_o.sample = afd_pkg::SampleMin;
    end else begin
      calc_o.sample = $signed(shifted[afd_pkg::SampleW-1:0]);
    end
  end

endmodule

### design/adpcm_frame_decoder.sv
// 4-bit frame adpcm decoder
//
// in_if_i carries one clip byte per beat plus a last-byte flag. frames are 8 bytes:
// a header (scale exponent in the low nibble, coefficient pair in bits 6:4) and
// seven data bytes that each give two 16-bit samples, high nibble first.
// out_if_o carries one sample per beat with a clip flag and run_end, which marks
// the last sample that a given input byte produced.
// coefficients and the per-clip sample limit are written through the cfg_* port.
// the user must write them only while the decoder is idle; the decoder itself does
// not enforce this. unused register indexes are dropped.
// a byte passes through the byte holding stage, then its first sample through
// the output register. each sample takes one predictor evaluation, and the
// second sample of a data byte needs the first as history; a header byte, or a
// byte past the sample limit, produces no beat.
// the output register lets the next byte be taken while a sample waits; when
// the receiver stalls, the decoder holds the pending nibble and backs up into
// in_if_i.ready.
// reset clears history, frame position, count and the output valid flag, zeroes
// the coefficients and sets the sample limit to its maximum. a byte with
// last_byte set returns the clip state to zero once it is fully handled.
module adpcm_frame_decoder #(
  parameter int unsigned COUNT_WIDTH = 24
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  afd_in_if.sink                          in_if_i,
  afd_out_if.source                       out_if_o,
  input  logic                            cfg_we_i,
  input  logic [afd_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [afd_pkg::CfgDataW-1:0]    cfg_data_i
);

  // width for comparing the running count against the 24-bit limit
  localparam int unsigned CmpW = (COUNT_WIDTH > afd_pkg::LimitW) ? COUNT_WIDTH
                                                                 : afd_pkg::LimitW;

  // configuration registers
  logic [afd_pkg::CfgDataW-1:0] coef_q [afd_pkg::NumCoefWords];
  logic [afd_pkg::LimitW-1:0]   limit_q;

  // clip state
  logic signed [afd_pkg::SampleW-1:0] hist_new_q, hist_new_d;
  logic signed [afd_pkg::SampleW-1:0] hist_old_q, hist_old_d;
  logic [afd_pkg::PosW-1:0]           pos_q, pos_d;
  logic [afd_pkg::ScaleW-1:0]         scale_q, scale_d;
  logic [afd_pkg::PredW-1:0]          pred_q, pred_d;
  logic [COUNT_WIDTH-1:0]             count_q, count_d;

  // byte holding stage
  logic                      busy_q, busy_d;
  logic                      lo_q, lo_d;     // high nibble done, low nibble next
  logic [afd_pkg::ByteW-1:0] byte_q;
  logic                      last_q;

  // output register
  logic                               out_valid_q, out_valid_d;
  logic signed [afd_pkg::SampleW-1:0] pcm_q;
  logic                               clip_q;
  logic                               end_q;

  // step control
  logic                   in_accept;
  logic                   slot_free;
  logic                   below_limit;
  logic                   inc_below;
  logic [COUNT_WIDTH-1:0] count_inc;
  logic                   is_data;
  logic                   is_header;
  logic                   can_step;
  logic                   step_fin;
  logic                   emit;
  logic                   emit_end;

  logic [afd_pkg::CfgDataW-1:0]   coef_word;
  logic [2*afd_pkg::CoefW-1:0]    coef_pair;
  afd_pkg::calc_in_t              calc_in;
  afd_pkg::calc_out_t             calc_out;

  // ---------------------------------------------------------------- control
  assign slot_free   = !out_valid_q || out_if_o.ready;
  assign count_inc   = count_q + 1'b1;
  assign below_limit = CmpW'(count_q) < CmpW'(limit_q);
  assign inc_below   = CmpW'(count_inc) < CmpW'(limit_q);

  // low nibble always decodes; a fresh byte decodes only below the limit past the header
  assign is_data   = busy_q && (lo_q || (below_limit && (pos_q != afd_pkg::PosHeader)));
  assign is_header = busy_q && !lo_q && below_limit && (pos_q == afd_pkg::PosHeader);

  // a decoding step needs room in the output register, others go through at once
  assign can_step = busy_q && (!is_data || slot_free);
  assign emit     = can_step && is_data;
  // the byte is finished after its low nibble, or after the high one at the limit
  assign emit_end = lo_q || !inc_below;
  assign step_fin = can_step && (!is_data || emit_end);

  assign in_if_i.ready = !busy_q || step_fin;
  assign in_accept     = in_if_i.valid && in_if_i.ready;

  // ------------------------------------------------------------- datapath
  // pair p sits in word p/2, low or high half
  assign coef_word = coef_q[pred_q[afd_pkg::PredW-1:1]];
  assign coef_pair = pred_q[0] ? coef_word[afd_pkg::CfgDataW-1:2*afd_pkg::CoefW]
                               : coef_word[2*afd_pkg::CoefW-1:0];

  always_comb begin
    calc_in.nibble     = lo_q ? byte_q[afd_pkg::NibW-1:0]
                              : byte_q[afd_pkg::ByteW-1:afd_pkg::NibW];
    calc_in.scale_exp  = scale_q;
    calc_in.coef_newer = $signed(coef_pair[afd_pkg::CoefW-1:0]);
    calc_in.coef_older = $signed(coef_pair[2*afd_pkg::CoefW-1:afd_pkg::CoefW]);
    calc_in.hist_newer = hist_new_q;
    calc_in.hist_older = hist_old_q;
  end

  afd_sample_calc u_calc (
    .calc_i (calc_in),
    .calc_o (calc_out)
  );

  // ---------------------------------------------------------- clip state
  function automatic logic [afd_pkg::ScaleW-1:0] in_hdr_scale(
    input logic [afd_pkg::ByteW-1:0] hdr
  );
    return hdr[afd_pkg::ScaleW-1:0];
  endfunction

  always_comb begin
    hist_new_d = hist_new_q;
    hist_old_d = hist_old_q;
    pos_d      = pos_q;
    scale_d    = scale_q;
    pred_d     = pred_q;
    count_d    = count_q;

    if (can_step && is_header) begin
      scale_d = in_hdr_scale(byte_q);
      pred_d  = byte_q[afd_pkg::NibW+afd_pkg::PredW-1:afd_pkg::NibW];
      pos_d   = afd_pkg::PosFirstData;
    end

    if (emit) begin
      hist_old_d = hist_new_q;
      hist_new_d = calc_out.sample;
      count_d    = count_inc;
    end

    // frame position moves on once per data byte
    if (step_fin && is_data) begin
      pos_d = (pos_q >= afd_pkg::FrameDataBytes) ? afd_pkg::PosHeader
                                                 : pos_q + 1'b1;
    end

    // end of clip: back to a fresh start
    if (step_fin && last_q) begin
      hist_new_d = '0;
      hist_old_d = '0;
      pos_d      = afd_pkg::PosHeader;
      scale_d    = '0;
      pred_d     = '0;
      count_d    = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hist_new_q <= '0;
      hist_old_q <= '0;
      pos_q      <= afd_pkg::PosHeader;
      scale_q    <= '0;
      pred_q     <= '0;
      count_q    <= '0;
    end else begin
      hist_new_q <= hist_new_d;
      hist_old_q <= hist_old_d;
      pos_q      <= pos_d;
      scale_q    <= scale_d;
      pred_q     <= pred_d;
      count_q    <= count_d;
    end
  end

  // ------------------------------------------------------ byte holding stage
  always_comb begin
    busy_d = busy_q;
    lo_d   = lo_q;
    if (emit && !step_fin) begin
      lo_d = 1'b1;
    end
    if (step_fin) begin
      busy_d = 1'b0;
      lo_d   = 1'b0;
    end
    if (in_accept) begin
      busy_d = 1'b1;
      lo_d   = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      lo_q   <= 1'b0;
    end else begin
      busy_q <= busy_d;
      lo_q   <= lo_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      byte_q <= in_if_i.data_byte;
      last_q <= in_if_i.last_byte;
    end
  end

  // ------------------------------------------------------ output register
  always_comb begin
    out_valid_d = out_valid_q;
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (out_if_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      pcm_q  <= calc_out.sample;
      clip_q <= calc_out.clipped;
      end_q  <= emit_end;
    end
  end

  assign out_if_o.valid       = out_valid_q;
  assign out_if_o.pcm_sample  = pcm_q;
  assign out_if_o.was_clipped = clip_q;
  assign out_if_o.run_end     = end_q;

  // ------------------------------------------------------ configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < afd_pkg::NumCoefWords; i++) begin
        coef_q[i] <= '0;
      end
      limit_q <= afd_pkg::LimitReset;
    end else if (cfg_we_i) begin
      case (afd_pkg::cfg_idx_e'(cfg_idx_i))
        afd_pkg::CFG_COEF_A,
        afd_pkg::CFG_COEF_B,
        afd_pkg::CFG_COEF_C,
        afd_pkg::CFG_COEF_D: begin
          coef_q[cfg_idx_i[1:0]] <= cfg_data_i;
        end
        afd_pkg::CFG_SAMPLE_LIMIT: begin
          limit_q <= cfg_data_i[afd_pkg::LimitW-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // ------------------------------------------------------ assertions
  // a high nibble that does not end the byte leaves the low nibble pending
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && !step_fin) |=> (busy_q && lo_q))
    else $error("low nibble not pending after high nibble");

  // a pending low nibble only exists inside a frame's data bytes
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && lo_q) |-> (pos_q != afd_pkg::PosHeader))
    else $error("low nibble pending at header position");

  // a last byte leaves the clip state cleared
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_fin && last_q) |=> (count_q == '0 && pos_q == afd_pkg::PosHeader &&
                              hist_new_q == '0 && hist_old_q == '0))
    else $error("clip state not cleared after last byte");

  // a new output beat only comes from a decode step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(emit))
    else $error("output valid without decode step");

endmodule
